### rtl/core/kqs_pkg.sv
// ----------------------------------------------------------------------------
// kqs_pkg: shared types and constants of the quadratic rank selector
// Word widths, parameter defaults and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kqs_pkg;

  // Fixed field widths
  localparam int unsigned RANK_W = 21;   // rank field
  localparam int unsigned KTH_W  = 57;   // result field
  localparam int unsigned VAL_W  = 64;   // wrapping evaluation width

  // Parameter defaults
  localparam int unsigned MAX_RANK_DEF  = 1048576;
  localparam int unsigned COEF_BITS_DEF = 16;

  // Which sequence and which point to evaluate
  typedef enum logic [1:0] {
    EV_A_I   = 2'd0,   // a(i)
    EV_A_IM1 = 2'd1,   // a(i-1)
    EV_B_J   = 2'd2,   // b(j)
    EV_B_JM1 = 2'd3    // b(j-1)
  } eval_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;        // capture a new input word
    logic      split;       // i = (lo+hi)/2, j = n-i
    logic      lo_up;       // lo = i+1
    logic      hi_down;     // hi = i-1
    logic      eval_start;  // launch one polynomial evaluation
    eval_sel_e eval_sel;
    logic      save_va;     // keep the evaluation as the a-side value
    logic      save_vb;     // keep the evaluation as the b-side value
    logic      res_zero;    // result = 0 (search ran out)
    logic      res_val;     // result = latest evaluation
    logic      res_va;      // result = saved a-side value
    logic      out_load;    // move result into the output register
  } kqs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_order;   // lo <= hi
    logic i_zero;
    logic j_zero;
    logic i_lt_n;
    logic j_lt_n;
    logic eval_done;  // evaluation value valid this cycle
    logic vb_gt;      // saved b-side value > evaluation
    logic va_gt;      // saved a-side value > evaluation
    logic out_free;   // output register can take a word
  } kqs_stat_t;

endpackage

`default_nettype wire

### rtl/core/kth_of_two_quadratic_sequences_unit.sv
// Search: S steps on the split point, S <= floor(log2(rank+1))+1 (21 at the
//   largest rank); a search that runs out gives the result zero, and the
//   result word may wait for the output register.
// Throughput: one word at a time; each polynomial evaluation uses the single
//   shared 33-bit multiplier (two passes per product, two products).
// Reset: asynchronous, active low; clears the sequencer, evaluator and out valid.
// ----------------------------------------------------------------------------
// kth_of_two_quadratic_sequences_unit: rank selection over two quadratics
// Returns the rank-th smallest element of the merge of a(i)=a2*i*i+a1*i+a0
// and b(j)=b2*j*j+b1*j+b0 by a binary search on the split point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kth_of_two_quadratic_sequences_unit
  import kqs_pkg::*;
#(
  parameter int unsigned MAX_RANK  = MAX_RANK_DEF,
  parameter int unsigned COEF_BITS = COEF_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [COEF_BITS-1:0] coef_a2_i,
  input  wire logic signed [COEF_BITS-1:0] coef_a1_i,
  input  wire logic signed [COEF_BITS-1:0] coef_a0_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b2_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b1_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b0_i,
  input  wire logic [RANK_W-1:0]           rank_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [KTH_W-1:0]          kth_value_o
);

  // Rank bits, and signed width for bounds and split points: lo+hi
  // is at most 2*rank and the evaluation point can drop to -1.
  localparam int unsigned NB = $clog2(MAX_RANK + 1);
  localparam int unsigned SW = NB + 2;

  kqs_cmd_t  cmd;
  kqs_stat_t stat;
  logic      idle;

  // The sequencer only takes a word in its idle state. A finished word
  // waits in the output register, so the next word can start meanwhile.
  kqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  // Bounds, split point, saved a/b values, evaluator and output register
  kqs_datapath #(
    .MAX_RANK  (MAX_RANK),
    .COEF_BITS (COEF_BITS),
    .NB        (NB),
    .SW        (SW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .coef_a2_i   (coef_a2_i),
    .coef_a1_i   (coef_a1_i),
    .coef_a0_i   (coef_a0_i),
    .coef_b2_i   (coef_b2_i),
    .coef_b1_i   (coef_b1_i),
    .coef_b0_i   (coef_b0_i),
    .rank_i      (rank_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kth_value_o (kth_value_o)
  );

  // Hold off new words while a search is running
  assign in_stall_o = !idle;

endmodule

`default_nettype wire

### rtl/core/kqs_quad_eval.sv
// ----------------------------------------------------------------------------
// kqs_quad_eval: shared quadratic evaluator
// Computes (c2*t + c1)*t + c0 modulo 2^64 with one 33-bit by SW-bit
// multiplier, two passes per product (low half, then high half).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kqs_quad_eval
  import kqs_pkg::*;
#(
  parameter int unsigned COEF_BITS = COEF_BITS_DEF,
  parameter int unsigned SW        = 23
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [COEF_BITS-1:0] c2_i,
  input  wire logic signed [COEF_BITS-1:0] c1_i,
  input  wire logic signed [COEF_BITS-1:0] c0_i,
  input  wire logic signed [SW-1:0]        t_i,
  output logic signed [VAL_W-1:0]          value_o,
  output logic                             done_o
);

  localparam int unsigned HALF_W = VAL_W / 2;
  localparam int unsigned PW     = HALF_W + 1 + SW;

  logic                        busy_q;
  logic [1:0]                  step_q;
  logic                        done_q;
  logic [VAL_W-1:0]            acc_q, acc_d;
  logic [VAL_W-1:0]            part_q;
  logic signed [COEF_BITS-1:0] c1_q, c0_q;
  logic signed [SW-1:0]        t_q;

  logic signed [HALF_W:0]      a_op;
  logic signed [PW-1:0]        prod;
  logic [VAL_W-1:0]            prod_ext;
  logic signed [COEF_BITS-1:0] addend_c;
  logic [VAL_W-1:0]            addend;

  // step[0] picks the half of the accumulator, step[1] the addend
  assign a_op     = $signed({1'b0, (step_q[0] ? acc_q[VAL_W-1:HALF_W] : acc_q[HALF_W-1:0])});
  assign prod     = a_op * t_q;
  assign prod_ext = {{(VAL_W-PW){prod[PW-1]}}, prod};
  assign addend_c = step_q[1] ? c0_q : c1_q;
  assign addend   = {{(VAL_W-COEF_BITS){addend_c[COEF_BITS-1]}}, addend_c};
  assign acc_d    = part_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}} + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{(VAL_W-COEF_BITS){c2_i[COEF_BITS-1]}}, c2_i};
      c1_q  <= c1_i;
      c0_q  <= c0_i;
      t_q   <= t_i;
    end else if (busy_q) begin
      if (!step_q[0]) begin
        part_q <= prod_ext;
      end else begin
        acc_q <= acc_d;
      end
    end
  end

  assign value_o = $signed(acc_q);
  assign done_o  = done_q;

endmodule

`default_nettype wire

### rtl/core/kqs_datapath.sv
// ----------------------------------------------------------------------------
// kqs_datapath: search bounds, saved values and output register
// Holds the item, the split search state and the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kqs_datapath
  import kqs_pkg::*;
#(
  parameter int unsigned MAX_RANK  = MAX_RANK_DEF,
  parameter int unsigned COEF_BITS = COEF_BITS_DEF,
  parameter int unsigned NB        = 21,
  parameter int unsigned SW        = 23
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kqs_cmd_t                    cmd_i,
  output kqs_stat_t                        stat_o,
  input  wire logic signed [COEF_BITS-1:0] coef_a2_i,
  input  wire logic signed [COEF_BITS-1:0] coef_a1_i,
  input  wire logic signed [COEF_BITS-1:0] coef_a0_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b2_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b1_i,
  input  wire logic signed [COEF_BITS-1:0] coef_b0_i,
  input  wire logic [RANK_W-1:0]           rank_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic signed [KTH_W-1:0]          kth_value_o
);

  localparam int unsigned CW = (RANK_W > NB) ? RANK_W : NB;
  localparam logic [CW-1:0]        MAX_C = CW'(MAX_RANK);
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  logic signed [COEF_BITS-1:0] a2_q, a1_q, a0_q, b2_q, b1_q, b0_q;
  logic [NB-1:0]               n_q;
  logic signed [SW-1:0]        lo_q, hi_q, i_q, j_q;
  logic signed [VAL_W-1:0]     va_q, vb_q, res_q;
  logic                        out_valid_q;
  logic signed [KTH_W-1:0]     kth_q;

  logic [CW-1:0]               rank_c, n_sat;
  logic [NB-1:0]               n_new;
  logic signed [SW-1:0]        n_s, sum, i_d, j_d, t_sel;
  logic signed [COEF_BITS-1:0] c2_sel, c1_sel, c0_sel;
  logic signed [VAL_W-1:0]     ev_val;
  logic                        ev_done;

  // Saturate the rank
  assign rank_c = CW'(rank_i);
  assign n_sat  = (rank_c > MAX_C) ? MAX_C : rank_c;
  assign n_new  = n_sat[NB-1:0];

  assign n_s = $signed({2'b00, n_q});
  assign sum = lo_q + hi_q;
  assign i_d = sum >>> 1;
  assign j_d = n_s - i_d;

  always_comb begin
    unique case (cmd_i.eval_sel)
      EV_A_I:   t_sel = i_q;
      EV_A_IM1: t_sel = i_q - ONE_S;
      EV_B_J:   t_sel = j_q;
      EV_B_JM1: t_sel = j_q - ONE_S;
      default:  t_sel = i_q;
    endcase
  end

  always_comb begin
    if (cmd_i.eval_sel == EV_A_I || cmd_i.eval_sel == EV_A_IM1) begin
      c2_sel = a2_q;
      c1_sel = a1_q;
      c0_sel = a0_q;
    end else begin
      c2_sel = b2_q;
      c1_sel = b1_q;
      c0_sel = b0_q;
    end
  end

  kqs_quad_eval #(
    .COEF_BITS (COEF_BITS),
    .SW        (SW)
  ) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.eval_start),
    .c2_i    (c2_sel),
    .c1_i    (c1_sel),
    .c0_i    (c0_sel),
    .t_i     (t_sel),
    .value_o (ev_val),
    .done_o  (ev_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a2_q <= coef_a2_i;
      a1_q <= coef_a1_i;
      a0_q <= coef_a0_i;
      b2_q <= coef_b2_i;
      b1_q <= coef_b1_i;
      b0_q <= coef_b0_i;
      n_q  <= n_new;
      lo_q <= '0;
      hi_q <= $signed({2'b00, n_new});
    end
    if (cmd_i.split) begin
      i_q <= i_d;
      j_q <= j_d;
    end
    if (cmd_i.lo_up) begin
      lo_q <= i_q + ONE_S;
    end
    if (cmd_i.hi_down) begin
      hi_q <= i_q - ONE_S;
    end
    if (cmd_i.save_va) begin
      va_q <= ev_val;
    end
    if (cmd_i.save_vb) begin
      vb_q <= ev_val;
    end
    priority if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.res_va) begin
      res_q <= va_q;
    end else if (cmd_i.res_val) begin
      res_q <= ev_val;
    end
    if (cmd_i.out_load) begin
      kth_q <= res_q[KTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.in_order  = (lo_q <= hi_q);
    stat_o.i_zero    = (i_q == '0);
    stat_o.j_zero    = (j_q == '0);
    stat_o.i_lt_n    = (i_q < n_s);
    stat_o.j_lt_n    = (j_q < n_s);
    stat_o.eval_done = ev_done;
    stat_o.vb_gt     = (vb_q > ev_val);
    stat_o.va_gt     = (va_q > ev_val);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;

endmodule

`default_nettype wire

### rtl/core/kqs_ctrl.sv
// ----------------------------------------------------------------------------
// kqs_ctrl: search sequencer
// Walks the binary search on the split point and orders the evaluations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kqs_ctrl
  import kqs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire kqs_stat_t stat_i,
  output kqs_cmd_t       cmd_o,
  output logic           idle_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SPLIT = 12'b0000_0000_0010,
    S_CHK1  = 12'b0000_0000_0100,
    S_E1B   = 12'b0000_0000_1000,
    S_E1A   = 12'b0000_0001_0000,
    S_CHK2  = 12'b0000_0010_0000,
    S_E2A   = 12'b0000_0100_0000,
    S_E2B   = 12'b0000_1000_0000,
    S_FIN   = 12'b0001_0000_0000,
    S_FA    = 12'b0010_0000_0000,
    S_FB    = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (stat_i.in_order) begin
          cmd_o.split = 1'b1;
          state_d     = S_CHK1;
        end else begin
          cmd_o.res_zero = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_CHK1: begin
        // need b(j-1) > a(i) to move lo up
        if (stat_i.i_lt_n && !stat_i.j_zero) begin
          cmd_o.eval_start = 1'b1;
          cmd_o.eval_sel   = EV_B_JM1;
          state_d          = S_E1B;
        end else begin
          state_d = S_CHK2;
        end
      end
      S_E1B: begin
        if (stat_i.eval_done) begin
          cmd_o.save_vb    = 1'b1;
          cmd_o.eval_start = 1'b1;
          cmd_o.eval_sel   = EV_A_I;
          state_d          = S_E1A;
        end
      end
      S_E1A: begin
        if (stat_i.eval_done) begin
          if (stat_i.vb_gt) begin
            cmd_o.lo_up = 1'b1;
            state_d     = S_SPLIT;
          end else begin
            state_d = S_CHK2;
          end
        end
      end
      S_CHK2: begin
        // need a(i-1) > b(j) to move hi down
        if (!stat_i.i_zero && stat_i.j_lt_n) begin
          cmd_o.eval_start = 1'b1;
          cmd_o.eval_sel   = EV_A_IM1;
          state_d          = S_E2A;
        end else begin
          state_d = S_FIN;
        end
      end
      S_E2A: begin
        if (stat_i.eval_done) begin
          cmd_o.save_va    = 1'b1;
          cmd_o.eval_start = 1'b1;
          cmd_o.eval_sel   = EV_B_J;
          state_d          = S_E2B;
        end
      end
      S_E2B: begin
        if (stat_i.eval_done) begin
          if (stat_i.va_gt) begin
            cmd_o.hi_down = 1'b1;
            state_d       = S_SPLIT;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd_o.eval_start = 1'b1;
        if (stat_i.i_zero) begin
          cmd_o.eval_sel = EV_B_JM1;
          state_d        = S_FB;
        end else begin
          cmd_o.eval_sel = EV_A_IM1;
          state_d        = S_FA;
        end
      end
      S_FA: begin
        if (stat_i.eval_done) begin
          if (stat_i.j_zero) begin
            cmd_o.res_val = 1'b1;
            state_d       = S_OUT;
          end else begin
            cmd_o.save_va    = 1'b1;
            cmd_o.eval_start = 1'b1;
            cmd_o.eval_sel   = EV_B_JM1;
            state_d          = S_FB;
          end
        end
      end
      S_FB: begin
        if (stat_i.eval_done) begin
          // larger of the two left-side values
          if (!stat_i.i_zero && stat_i.va_gt) begin
            cmd_o.res_va = 1'b1;
          end else begin
            cmd_o.res_val = 1'b1;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

### rtl/core/kqs_checker.sv
// ----------------------------------------------------------------------------
// kqs_checker: port-level checks of the rank selector
// Tracks words in flight and checks ordering of the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kqs_checker
  import kqs_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic signed [KTH_W-1:0] kth_value_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kth_value_o))
    else $error("result word changed while stalled");

  // Accepting a word starts a search
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // No result without a word in flight
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result word with no input in flight");

  // One word in the search, at most one waiting
  a_in_flight_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many words in flight");

  // A result comes out of a running search
  a_rose_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind kth_of_two_quadratic_sequences_unit kqs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kth_value_o (kth_value_o)
);

`default_nettype wire

### dv/kth_of_two_quadratic_sequences_unit_test.sv
// ----------------------------------------------------------------------------
// kth_of_two_quadratic_sequences_unit_test: self-checking bench of the unit
// Sends words of six coefficients and a rank, predicts the selected element
// with a local binary-search model, and compares every result word in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kth_of_two_quadratic_sequences_unit_test;
  import kqs_pkg::*;

  localparam int unsigned CW       = COEF_BITS_DEF;
  localparam int unsigned RANK_CAP = MAX_RANK_DEF;
  localparam int unsigned RANK_TOP = (1 << RANK_W) - 1;

  typedef struct {
    logic signed [CW-1:0] a2;
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a0;
    logic signed [CW-1:0] b2;
    logic signed [CW-1:0] b1;
    logic signed [CW-1:0] b0;
    logic [RANK_W-1:0]    rank;
  } seq_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [CW-1:0] coef_a2_i;
  logic signed [CW-1:0] coef_a1_i;
  logic signed [CW-1:0] coef_a0_i;
  logic signed [CW-1:0] coef_b2_i;
  logic signed [CW-1:0] coef_b1_i;
  logic signed [CW-1:0] coef_b0_i;
  logic [RANK_W-1:0]    rank_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [KTH_W-1:0] kth_value_o;

  // Expected selected elements, oldest first
  logic [KTH_W-1:0] kth_expected[$];

  int unsigned failures;
  int unsigned words_sent;
  int unsigned ordered_sent;
  int unsigned unordered_sent;
  int unsigned results_checked;

  // Idle shaping: when set, that side never inserts gaps or stalls
  logic steady_in;
  logic steady_out;

  kth_of_two_quadratic_sequences_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coef_a2_i   (coef_a2_i),
    .coef_a1_i   (coef_a1_i),
    .coef_a0_i   (coef_a0_i),
    .coef_b2_i   (coef_b2_i),
    .coef_b1_i   (coef_b1_i),
    .coef_b0_i   (coef_b0_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kth_value_o (kth_value_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Evaluate c2*t*t + c1*t + c0 with 64-bit wrap; t may be -1.
  function automatic logic signed [63:0] poly_value(input logic signed [CW-1:0] c2,
                                                     input logic signed [CW-1:0] c1,
                                                     input logic signed [CW-1:0] c0,
                                                     input logic signed [63:0] t);
    logic signed [63:0] w2, w1, w0;
    w2 = c2;
    w1 = c1;
    w0 = c0;
    return w2 * t * t + w1 * t + w0;
  endfunction

  // Rank selection over the merge: binary search on the split i, j = n - i.
  function automatic logic [KTH_W-1:0] kth_of_merge(input seq_word_t w);
    logic signed [63:0] n, lo, hi, i, j, va, vb, pick;
    logic settled;
    if (w.rank > RANK_CAP) begin
      n = RANK_CAP;
    end else begin
      n = w.rank;
    end
    lo      = 0;
    hi      = n;
    pick    = 0;      // stays zero when the bounds cross unsettled
    settled = 1'b0;
    while (!settled && lo <= hi) begin
      i = (lo + hi) / 2;
      j = n - i;
      if (i < n && j > 0 &&
          poly_value(w.b2, w.b1, w.b0, j - 1) > poly_value(w.a2, w.a1, w.a0, i)) begin
        lo = i + 1;
      end else if (i > 0 && j < n &&
                   poly_value(w.a2, w.a1, w.a0, i - 1) >
                   poly_value(w.b2, w.b1, w.b0, j)) begin
        hi = i - 1;
      end else begin
        settled = 1'b1;
        va = poly_value(w.a2, w.a1, w.a0, i - 1);
        vb = poly_value(w.b2, w.b1, w.b0, j - 1);
        if (i == 0) begin
          pick = vb;
        end else if (j == 0) begin
          pick = va;
        end else begin
          pick = (va > vb) ? va : vb;
        end
      end
    end
    return pick[KTH_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------

  function automatic seq_word_t make_word(input int a2, input int a1, input int a0,
                                          input int b2, input int b1, input int b0,
                                          input int unsigned rank);
    seq_word_t w;
    w.a2   = a2[CW-1:0];
    w.a1   = a1[CW-1:0];
    w.a0   = a0[CW-1:0];
    w.b2   = b2[CW-1:0];
    w.b1   = b1[CW-1:0];
    w.b0   = b0[CW-1:0];
    w.rank = rank[RANK_W-1:0];
    return w;
  endfunction

  // Mostly short searches, a few at the full rank range (saturating ranks too).
  function automatic int unsigned random_rank();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom_range(1, 64);
    if (sel <= 7) return $urandom_range(1, 4096);
    if (sel == 8) return $urandom_range(1, RANK_TOP);
    return $urandom_range(RANK_CAP - 16, RANK_CAP);
  endfunction

  // Slope pair (p, q) with p >= 0 and p + q >= 0: nondecreasing for t >= 0.
  // Small magnitudes are frequent so that equal elements and ties show up.
  function automatic void rising_slope(output int p, output int q);
    int unsigned p_top;
    case ($urandom_range(0, 2))
      0:       p_top = 0;
      1:       p_top = 7;
      default: p_top = 32767;
    endcase
    p = $urandom_range(0, p_top);
    if ($urandom_range(0, 1) == 0) begin
      q = int'($urandom_range(0, 8 + p)) - p;
    end else begin
      q = int'($urandom_range(0, 32767 + p)) - p;
    end
  endfunction

  function automatic seq_word_t ordered_word();
    int pa, qa, pb, qb;
    rising_slope(pa, qa);
    rising_slope(pb, qb);
    return make_word(pa, qa, int'($urandom), pb, qb, int'($urandom), random_rank());
  endfunction

  // Broken sequence: p + q < 0 on one side, so the order breaks at t = 0.
  function automatic seq_word_t broken_word();
    int pa, qa, pb, qb;
    rising_slope(pa, qa);
    rising_slope(pb, qb);
    if ($urandom_range(0, 1) == 0) begin
      qa = -pa - 1 - int'($urandom_range(0, 32767 - pa));
    end else begin
      qb = -pb - 1 - int'($urandom_range(0, 32767 - pb));
    end
    return make_word(pa, qa, int'($urandom), pb, qb, int'($urandom), random_rank());
  endfunction

  function automatic seq_word_t noise_word();
    return make_word(int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom), int'($urandom), random_rank());
  endfunction

  // --------------------------------------------------------------------------
  // Input side: send one word, record its expected result on acceptance
  // --------------------------------------------------------------------------

  // Entered and left at a falling edge; valid stays high when the next word
  // follows without a gap.
  task automatic send_word(input seq_word_t w, input logic ordered);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coef_a2_i  <= w.a2;
    coef_a1_i  <= w.a1;
    coef_a0_i  <= w.a0;
    coef_b2_i  <= w.b2;
    coef_b1_i  <= w.b1;
    coef_b0_i  <= w.b0;
    rank_i     <= w.rank;
    in_valid_i <= 1'b1;
    // hold the word until an edge sees it unstalled
    do @(posedge clk_i); while (in_stall_o);
    kth_expected.push_back(kth_of_merge(w));
    words_sent++;
    if (ordered) ordered_sent++;
    else unordered_sent++;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall per result word, then compare in order
  // --------------------------------------------------------------------------

  initial begin : result_stall
    int unsigned hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = steady_out ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [KTH_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kth_expected.size() == 0) begin
        $error("kth_value: result %0d with no word outstanding", $signed(kth_value_o));
        failures++;
      end else begin
        want = kth_expected.pop_front();
        results_checked++;
        if (kth_value_o !== want) begin
          $error("kth_value mismatch: expected %0d, actual %0d",
                 $signed(want), $signed(kth_value_o));
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Coefficient extremes, ties and interleaved sequences.
  task automatic test_edge_coefficients();
    send_word(make_word(0, 0, 0, 0, 0, 0, 1), 1'b1);
    send_word(make_word(0, 0, 32767, 0, 0, -32768, 1), 1'b1);
    send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, RANK_CAP), 1'b1);
    send_word(make_word(32767, -32767, -32768, 1, 0, 0, RANK_CAP), 1'b1);
    send_word(make_word(0, 1, 0, 0, 1, 0, 2), 1'b1);
    send_word(make_word(0, 2, 0, 0, 2, 1, 5), 1'b1);
    send_word(make_word(0, 0, -32768, 0, 32767, 0, 1000), 1'b1);
    send_word(make_word(1, 0, 0, 0, 32767, -32768, 12345), 1'b1);
  endtask

  // Rank zero reads b(-1); ranks above the cap saturate.
  task automatic test_rank_limits();
    send_word(make_word(3, 4, 5, 5, -3, 7, 0), 1'b1);
    send_word(make_word(0, 0, 0, -32768, 32767, -32768, 0), 1'b0);
    send_word(make_word(2, -1, 9, 1, 1, -4, RANK_CAP + 1), 1'b1);
    send_word(make_word(7, 3, -100, 0, 5, 100, RANK_TOP), 1'b1);
    send_word(make_word(0, 1, 0, 0, 0, 0, RANK_CAP), 1'b1);
  endtask

  // Decreasing or broken sequences: the search may run out (result zero),
  // and large negative values exercise the wide end of the result.
  task automatic test_unordered_sequences();
    send_word(make_word(-1, 0, 0, -1, 0, 0, 100), 1'b0);
    send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, RANK_CAP), 1'b0);
    send_word(make_word(0, -32768, 32767, 0, 0, 0, 50), 1'b0);
    send_word(make_word(32767, -32768, 0, 0, 1, 0, 7), 1'b0);
  endtask

  // Nondecreasing pairs with random content, through each mix of idling.
  task automatic test_random_ordered(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      case ((4 * k) / count)
        0:       begin steady_in = 1'b1; steady_out = 1'b1; end
        1:       begin steady_in = 1'b0; steady_out = 1'b0; end
        2:       begin steady_in = 1'b0; steady_out = 1'b1; end
        default: begin steady_in = 1'b1; steady_out = 1'b0; end
      endcase
      send_word(ordered_word(), 1'b1);
    end
  endtask

  // Broken sequences and raw noise.
  task automatic test_random_noise(input int unsigned count);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 1) == 0) send_word(broken_word(), 1'b0);
      else send_word(noise_word(), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    failures        = 0;
    words_sent      = 0;
    ordered_sent    = 0;
    unordered_sent  = 0;
    results_checked = 0;
    steady_in       = 1'b0;
    steady_out      = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    out_stall_i     = 1'b0;
    coef_a2_i       = '0;
    coef_a1_i       = '0;
    coef_a0_i       = '0;
    coef_b2_i       = '0;
    coef_b1_i       = '0;
    coef_b0_i       = '0;
    rank_i          = '0;

    // hold reset, then release it on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_coefficients();
    test_rank_limits();
    test_unordered_sequences();
    test_random_ordered(380);
    test_random_noise(60);
    in_valid_i <= 1'b0;

    // drain, then allow one worst-case search for any stray word
    while (kth_expected.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("Sent %0d words (%0d on ordered sequences, %0d unordered or noise),",
             words_sent, ordered_sent, unordered_sent);
    $display("checked %0d results across rank zero, saturation and full-range ranks.",
             results_checked);
    if (failures == 0) begin
      $display("kth_of_two_quadratic_sequences_unit test passed");
    end else begin
      $display("kth_of_two_quadratic_sequences_unit test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3000000;
    $display("kth_of_two_quadratic_sequences_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
